/* rtl/camera_command_state_machine_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the camera command state machine
// ---------------------------------------------------------------------------
`ifndef CAMERA_COMMAND_STATE_MACHINE_MACROS_SVH
`define CAMERA_COMMAND_STATE_MACHINE_MACROS_SVH

// Condition that must hold at every clock edge outside reset
`define CCSM_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the same cycle
`define CCSM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/ccsm_pkg.sv */
// ---------------------------------------------------------------------------
// ccsm_pkg
// Types, codes and constants of the camera command state machine.
// ---------------------------------------------------------------------------
package ccsm_pkg;

  localparam int NumImagingParams = 2;
  localparam int IdxW = (NumImagingParams > 1) ? $clog2(NumImagingParams) : 1;

  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 16;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgCaptureTicks = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgReserveSize  = 1'd1;

  localparam logic [15:0] CaptureTicksRst = 16'd1000;
  localparam logic [15:0] ReserveSizeRst  = 16'd1024;

  // command and request codes
  localparam logic [7:0] CmdOpen        = 8'd0;
  localparam logic [7:0] CmdActivate    = 8'd1;
  localparam logic [7:0] CmdClose       = 8'd2;
  localparam logic [7:0] CmdSensorOn    = 8'd32;
  localparam logic [7:0] CmdSensorOff   = 8'd33;
  localparam logic [7:0] CmdSetParam    = 8'd34;
  localparam logic [7:0] CmdSelectParam = 8'd36;
  localparam logic [7:0] CmdConfigure   = 8'd38;
  localparam logic [7:0] CmdCapture     = 8'd39;
  localparam logic [7:0] ReqStatus      = 8'd129;
  localparam logic [7:0] ReqCloseErr    = 8'd133;
  localparam logic [7:0] ReqSessionId   = 8'd134;
  localparam logic [7:0] ReqSize        = 8'd135;
  localparam logic [7:0] ReqParam       = 8'd137;

  // session and capture phases
  localparam logic [1:0] SessClosed = 2'd0;
  localparam logic [1:0] SessOpen   = 2'd1;
  localparam logic [1:0] SessActive = 2'd2;
  localparam logic [1:0] CapIdle    = 2'd0;
  localparam logic [1:0] CapBusy    = 2'd2;

  localparam logic OpCommand = 1'b0;
  localparam logic OpTick    = 1'b1;

  typedef struct packed {
    logic              op;
    logic [7:0]        cmd_code;
    logic signed [31:0] arg_a;
    logic signed [31:0] arg_b;
  } in_t;

  typedef struct packed {
    logic [7:0]         resp_id;
    logic signed [31:0] word_a;
    logic [1:0]         word_b;
    logic               word_c;
    logic [1:0]         word_d;
    logic               word_e;
  } out_t;

  function automatic logic [31:0] param_rst(int i);
    logic [31:0] v;
    v = 32'd0;
    if (i == 0) v = 32'd2;
    else if (i == 1) v = 32'd4;
    return v;
  endfunction

endpackage

/* rtl/camera_command_state_machine.sv */
// ---------------------------------------------------------------------------
// camera_command_state_machine
// Command processor of an imaging sensor: session, sensor and capture control.
// ---------------------------------------------------------------------------
// Use:
//   Input channel (in_valid_i / in_stall_o / in_word_i) carries either a
//   command word (op = 0) or one time tick (op = 1). Requests (129, 133, 134,
//   135, 137) return one response word on the output channel
//   (out_valid_o / out_stall_i / out_word_o); everything else returns none.
//   A word is taken at an edge with valid high and stall low.
//   Path: a request taken into the input register gives its response in the
//   result register, where the receiver can take it; a result register that
//   is still full holds it back. Throughput: one word per cycle while nothing stalls,
//   set by the single pass of guarded updates between the two registers.
//   When the receiver stalls, the response holds in the result register; the
//   input register still drains words that give no response, and stalls the
//   sender only once a second response is waiting behind the first.
//   Configuration (cfg_we_i, cfg_idx_i, cfg_data_i) is to be written only
//   while idle; the block does not enforce it. Reset clears sessions to
//   closed, session number to all ones, table and both registers to defaults.
// ---------------------------------------------------------------------------
`include "camera_command_state_machine_macros.svh"

module camera_command_state_machine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  ccsm_pkg::in_t                       in_word_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output ccsm_pkg::out_t                      out_word_o,
  input  logic                                cfg_we_i,
  input  logic [ccsm_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [ccsm_pkg::CfgDataW-1:0]       cfg_data_i
);
  import ccsm_pkg::*;

  logic [15:0] capture_ticks_q, reserve_size_q;

  logic        in_valid_q;
  in_t         in_q;
  logic        out_valid_q;
  out_t        out_q;

  logic [15:0] session_num_q, session_num_d;
  logic [1:0]  session_phase_q, session_phase_d;
  logic        configured_q, configured_d;
  logic        sensor_on_q, sensor_on_d;
  logic [1:0]  capture_phase_q, capture_phase_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic [15:0] rep_size_q, rep_size_d;
  logic [31:0] table_q [NumImagingParams];
  logic        tbl_we;
  logic [IdxW-1:0] tbl_idx;
  logic [IdxW-1:0] sel_q, sel_d;

  logic        is_req, out_free, adv, idx_ok;
  logic [15:0] elapsed_inc;
  out_t        resp_d;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capture_ticks_q <= CaptureTicksRst;
      reserve_size_q  <= ReserveSizeRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgCaptureTicks: capture_ticks_q <= cfg_data_i;
        CfgReserveSize:  reserve_size_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake
  always_comb begin
    is_req   = (in_q.op == OpCommand) &&
               (in_q.cmd_code inside {ReqStatus, ReqCloseErr, ReqSessionId, ReqSize,
                                      ReqParam});
    out_free = !out_valid_q || !out_stall_i;
    adv      = in_valid_q && (!is_req || out_free);
  end

  assign in_stall_o  = in_valid_q && !adv;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_word_i;
    end
  end

  // one pass of guarded updates for the word in the input register
  always_comb begin
    session_num_d   = session_num_q;
    session_phase_d = session_phase_q;
    configured_d    = configured_q;
    sensor_on_d     = sensor_on_q;
    capture_phase_d = capture_phase_q;
    elapsed_d       = elapsed_q;
    rep_size_d      = rep_size_q;
    sel_d           = sel_q;
    tbl_we          = 1'b0;
    tbl_idx         = in_q.arg_a[IdxW-1:0];
    idx_ok          = $unsigned(in_q.arg_a) < 32'(NumImagingParams);
    elapsed_inc     = (elapsed_q != 16'hFFFF) ? elapsed_q + 16'd1 : elapsed_q;
    resp_d          = '0;
    resp_d.resp_id  = in_q.cmd_code;

    if (in_q.op == OpTick) begin
      if (capture_phase_q == CapBusy) begin
        elapsed_d = elapsed_inc;
        if (elapsed_inc >= capture_ticks_q) capture_phase_d = CapIdle;
      end
    end else begin
      case (in_q.cmd_code)
        CmdOpen: begin
          session_num_d   = session_num_q + 16'd1;
          session_phase_d = SessOpen;
        end
        CmdActivate: begin
          if (session_phase_q == SessOpen && configured_q) begin
            rep_size_d      = reserve_size_q;
            session_phase_d = SessActive;
          end
        end
        CmdClose: begin
          session_phase_d = SessClosed;
          configured_d    = 1'b0;
          sensor_on_d     = 1'b0;
          capture_phase_d = CapIdle;
        end
        CmdSensorOn:  sensor_on_d = 1'b1;
        CmdSensorOff: sensor_on_d = 1'b0;
        CmdSetParam: begin
          configured_d = 1'b0;
          tbl_we       = idx_ok;
        end
        CmdSelectParam: begin
          if (idx_ok) sel_d = in_q.arg_a[IdxW-1:0];
        end
        CmdConfigure: begin
          if (session_phase_q == SessOpen) configured_d = 1'b1;
        end
        CmdCapture: begin
          if (session_phase_q == SessActive && configured_q && sensor_on_q) begin
            capture_phase_d = CapBusy;
            elapsed_d       = 16'd0;
          end
        end
        ReqStatus: begin
          resp_d.word_a = 32'(session_phase_q);
          resp_d.word_b = {1'b0, configured_q};
          resp_d.word_c = sensor_on_q;
          resp_d.word_d = capture_phase_q;
        end
        ReqSessionId: resp_d.word_a = {{16{session_num_q[15]}}, session_num_q};
        ReqSize:      resp_d.word_a = {16'd0, rep_size_q};
        ReqParam: begin
          if (32'(sel_q) < 32'(NumImagingParams)) resp_d.word_a = table_q[sel_q];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      session_num_q   <= 16'hFFFF;
      session_phase_q <= SessClosed;
      configured_q    <= 1'b0;
      sensor_on_q     <= 1'b0;
      capture_phase_q <= CapIdle;
      elapsed_q       <= 16'd0;
      rep_size_q      <= 16'd0;
      sel_q           <= '0;
      for (int i = 0; i < NumImagingParams; i++) begin
        table_q[i] <= param_rst(i);
      end
    end else if (adv) begin
      session_num_q   <= session_num_d;
      session_phase_q <= session_phase_d;
      configured_q    <= configured_d;
      sensor_on_q     <= sensor_on_d;
      capture_phase_q <= capture_phase_d;
      elapsed_q       <= elapsed_d;
      rep_size_q      <= rep_size_d;
      sel_q           <= sel_d;
      if (tbl_we) table_q[tbl_idx] <= in_q.arg_b;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= adv && is_req;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && is_req) begin
      out_q <= resp_d;
    end
  end

  `CCSM_ASSERT_IMP(a_cfg_needs_session, configured_q, session_phase_q != SessClosed,
                   "configured while closed")
  `CCSM_ASSERT_IMP(a_cap_needs_session, capture_phase_q == CapBusy,
                   session_phase_q != SessClosed, "capture busy while closed")
  `CCSM_ASSERT_IMP(a_stall_cause, in_stall_o, out_valid_q && out_stall_i,
                   "input stalled with result slot free")
  `CCSM_ASSERT(a_phase_legal, session_phase_q <= SessActive, "illegal session phase")

endmodule

/* tb/camera_command_state_machine_tb.sv */
// ----------------------------------------------------------------------------
// camera_command_state_machine_tb
// Drives commands, requests and ticks into the camera command state machine.
// Each response is checked field by field against an in-bench model of the
// session, sensor, capture and parameter-table state. The run covers several
// register settings and several patterns of sender and receiver stalling.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module camera_command_state_machine_tb;
  import ccsm_pkg::*;

  localparam int CycleLimit = 400000;

  // Model of the block plus the queue of responses still owed
  class ccsm_scoreboard;
    logic [15:0]        capture_ticks;
    logic [15:0]        reserve_size;
    logic [15:0]        session_no;
    logic [15:0]        elapsed;
    logic [15:0]        reported_size;
    logic [1:0]         session_phase;
    logic [1:0]         capture_phase;
    logic               configured;
    logic               sensor_on;
    logic [31:0]        param_table [NumImagingParams];
    logic [IdxW-1:0]    sel_idx;
    out_t               responses_due [$];
    int                 errors;

    function new();
      capture_ticks = CaptureTicksRst;
      reserve_size  = ReserveSizeRst;
      session_no    = 16'hFFFF;
      elapsed       = '0;
      reported_size = '0;
      session_phase = SessClosed;
      capture_phase = CapIdle;
      configured    = 1'b0;
      sensor_on     = 1'b0;
      for (int i = 0; i < NumImagingParams; i++) param_table[i] = param_rst(i);
      sel_idx = '0;
      errors  = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      if (idx == CfgCaptureTicks) capture_ticks = data;
      else if (idx == CfgReserveSize) reserve_size = data;
    endfunction

    function void note_input(in_t w);
      out_t rsp;
      bit   answer;
      rsp    = '0;
      answer = 1'b0;
      if (w.op == OpTick) begin
        if (capture_phase == CapBusy) begin
          if (elapsed != 16'hFFFF) elapsed++;
          if (elapsed >= capture_ticks) capture_phase = CapIdle;
        end
        return;
      end
      case (w.cmd_code)
        CmdOpen: begin
          session_no++;
          session_phase = SessOpen;
        end
        CmdActivate: begin
          if (session_phase == SessOpen && configured) begin
            reported_size = reserve_size;
            session_phase = SessActive;
          end
        end
        CmdClose: begin
          session_phase = SessClosed;
          configured    = 1'b0;
          sensor_on     = 1'b0;
          capture_phase = CapIdle;
        end
        CmdSensorOn:  sensor_on = 1'b1;
        CmdSensorOff: sensor_on = 1'b0;
        CmdSetParam: begin
          configured = 1'b0;
          if (w.arg_a >= 0 && w.arg_a < NumImagingParams)
            param_table[w.arg_a[IdxW-1:0]] = w.arg_b;
        end
        CmdSelectParam: begin
          if (w.arg_a >= 0 && w.arg_a < NumImagingParams) sel_idx = w.arg_a[IdxW-1:0];
        end
        CmdConfigure: begin
          if (session_phase == SessOpen) configured = 1'b1;
        end
        CmdCapture: begin
          if (session_phase == SessActive && configured && sensor_on) begin
            capture_phase = CapBusy;
            elapsed       = '0;
          end
        end
        ReqStatus: begin
          answer      = 1'b1;
          rsp.word_a  = {30'd0, session_phase};
          rsp.word_b  = {1'b0, configured};
          rsp.word_c  = sensor_on;
          rsp.word_d  = capture_phase;
        end
        ReqCloseErr: answer = 1'b1;
        ReqSessionId: begin
          answer     = 1'b1;
          rsp.word_a = {{16{session_no[15]}}, session_no};
        end
        ReqSize: begin
          answer     = 1'b1;
          rsp.word_a = {16'd0, reported_size};
        end
        ReqParam: begin
          answer     = 1'b1;
          rsp.word_a = param_table[sel_idx];
        end
        default: ;
      endcase
      if (answer) begin
        rsp.resp_id = w.cmd_code;
        responses_due.push_back(rsp);
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (responses_due.size() == 0) begin
        $error("unexpected response word, resp_id %0d", got.resp_id);
        errors++;
        return;
      end
      want = responses_due.pop_front();
      if (got.resp_id !== want.resp_id) begin
        $error("resp_id: expected %0d, got %0d", want.resp_id, got.resp_id);
        errors++;
      end
      if (got.word_a !== want.word_a) begin
        $error("word_a: expected %0d, got %0d", want.word_a, got.word_a);
        errors++;
      end
      if (got.word_b !== want.word_b) begin
        $error("word_b: expected %0d, got %0d", want.word_b, got.word_b);
        errors++;
      end
      if (got.word_c !== want.word_c) begin
        $error("word_c: expected %0d, got %0d", want.word_c, got.word_c);
        errors++;
      end
      if (got.word_d !== want.word_d) begin
        $error("word_d: expected %0d, got %0d", want.word_d, got.word_d);
        errors++;
      end
      if (got.word_e !== want.word_e) begin
        $error("word_e: expected %0d, got %0d", want.word_e, got.word_e);
        errors++;
      end
    endfunction

    function int pending();
      return responses_due.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  in_t                 in_word_i;
  logic                out_valid_o;
  logic                out_stall_i;
  out_t                out_word_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  ccsm_scoreboard sb;
  int             in_idle_pct;
  int             out_idle_pct;
  int             hold_left;
  bit             pressure_req;
  int             cycles;

  camera_command_state_machine DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: random stalls, or a long hold-off when asked for one
  initial begin
    out_stall_i = 1'b0;
    hold_left   = 0;
    forever begin
      @(negedge clk_i);
      if (pressure_req) begin
        pressure_req = 1'b0;
        hold_left    = 80;
      end
      if (hold_left > 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else begin
        out_stall_i = ($urandom_range(0, 99) < out_idle_pct);
      end
    end
  end

  // Monitor: responses are checked before the word taken at the same edge is noted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_result(out_word_o);
      if (in_valid_i && !in_stall_o) sb.note_input(in_word_i);
      if (cfg_we_i) sb.write_reg(cfg_idx_i, cfg_data_i);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("camera_command_state_machine_tb failed");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_word(in_t w);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_word_i  = w;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic send_cmd(logic [7:0] id, logic [31:0] a, logic [31:0] b);
    in_t w;
    w.op       = OpCommand;
    w.cmd_code = id;
    w.arg_a    = a;
    w.arg_b    = b;
    send_word(w);
  endtask

  task automatic send_tick();
    in_t w;
    w.op       = OpTick;
    w.cmd_code = 8'($urandom_range(0, 255));
    w.arg_a    = $urandom;
    w.arg_b    = $urandom;
    send_word(w);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Waits until no response is owed; the further wait lets a trailing tick settle
  task automatic wait_drain();
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  // Full open-to-capture sequence with up to six ticks, returns the number of words sent
  task automatic run_capture_sequence(output int sent);
    int n;
    n = $urandom_range(0, 6);
    send_cmd(CmdOpen, $urandom, $urandom);
    send_cmd(CmdConfigure, $urandom, $urandom);
    send_cmd(CmdActivate, $urandom, $urandom);
    send_cmd(CmdSensorOn, $urandom, $urandom);
    send_cmd(CmdCapture, $urandom, $urandom);
    send_cmd(ReqStatus, $urandom, $urandom);
    repeat (n) send_tick();
    send_cmd(ReqStatus, $urandom, $urandom);
    sent = 7 + n;
  endtask

  function automatic in_t rand_word(output bit is_noise);
    in_t w;
    int  r;
    w.op       = OpCommand;
    w.cmd_code = CmdOpen;
    w.arg_a    = $urandom;
    w.arg_b    = $urandom;
    is_noise   = 1'b0;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      w.op       = OpTick;
      w.cmd_code = 8'($urandom_range(0, 255));
    end else if (r < 45) begin
      case ($urandom_range(0, 4))
        0: w.cmd_code = ReqStatus;
        1: w.cmd_code = ReqCloseErr;
        2: w.cmd_code = ReqSessionId;
        3: w.cmd_code = ReqSize;
        default: w.cmd_code = ReqParam;
      endcase
    end else if (r < 52) begin
      w.cmd_code = 8'($urandom_range(0, 255));
      is_noise   = 1'b1;
    end else begin
      case ($urandom_range(0, 11))
        0, 1:  w.cmd_code = CmdOpen;
        2:     w.cmd_code = CmdActivate;
        3:     w.cmd_code = CmdClose;
        4:     w.cmd_code = CmdSensorOn;
        5:     w.cmd_code = CmdSensorOff;
        6:     w.cmd_code = CmdSetParam;
        7:     w.cmd_code = CmdSelectParam;
        8, 9:  w.cmd_code = CmdConfigure;
        default: w.cmd_code = CmdCapture;
      endcase
      // mostly valid table indexes, now and then anything
      if ($urandom_range(0, 9) != 0) w.arg_a = $urandom_range(0, NumImagingParams - 1);
    end
    return w;
  endfunction

  initial begin
    in_t         w;
    bit          noise;
    int          count;
    int          sent;
    bit          pressure_done;
    logic [15:0] tick_set [6];
    logic [15:0] size_set [6];

    sb            = new();
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_word_i     = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    in_idle_pct   = 0;
    out_idle_pct  = 0;
    pressure_req  = 1'b0;
    pressure_done = 1'b0;
    cycles        = 0;

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: reset values, table bounds, guards, one capture, close
    send_tick();
    send_cmd(ReqStatus, '0, '0);
    send_cmd(ReqSessionId, '0, '0);
    send_cmd(ReqSize, '0, '0);
    send_cmd(ReqParam, '0, '0);
    send_cmd(CmdSelectParam, 32'd1, '0);
    send_cmd(ReqParam, '0, '0);
    send_cmd(CmdSelectParam, 32'hFFFF_FFFF, '0);
    send_cmd(CmdSelectParam, 32'd2, '0);
    send_cmd(CmdSetParam, 32'd1, 32'h8000_0000);
    send_cmd(CmdSetParam, 32'h8000_0000, 32'hFFFF_FFFF);
    send_cmd(ReqParam, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(CmdConfigure, '0, '0);
    send_cmd(CmdActivate, '0, '0);
    send_cmd(CmdOpen, '0, '0);
    send_cmd(CmdCapture, '0, '0);
    send_cmd(CmdConfigure, '0, '0);
    send_cmd(CmdActivate, '0, '0);
    send_cmd(ReqSize, '0, '0);
    send_cmd(CmdSensorOn, '0, '0);
    send_cmd(CmdCapture, '0, '0);
    send_tick();
    send_cmd(ReqStatus, '0, '0);
    send_cmd(CmdSensorOff, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_cmd(CmdClose, '0, '0);
    send_cmd(ReqCloseErr, '0, '0);
    send_cmd(8'hFF, '0, '0);
    wait_drain();

    tick_set[0] = 16'd1;      size_set[0] = 16'd0;
    tick_set[1] = 16'hFFFF;   size_set[1] = 16'hFFFF;
    tick_set[2] = 16'd0;      size_set[2] = 16'($urandom);
    tick_set[3] = 16'($urandom_range(2, 8));  size_set[3] = 16'($urandom);
    tick_set[4] = 16'($urandom_range(1, 5));  size_set[4] = 16'($urandom);
    tick_set[5] = 16'd3;      size_set[5] = 16'($urandom);

    for (int p = 0; p < 6; p++) begin
      if (p < 2) begin
        in_idle_pct  = 19;
        out_idle_pct = 88;
      end else if (p < 4) begin
        in_idle_pct  = 88;
        out_idle_pct = 19;
      end else begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      write_reg(CfgCaptureTicks, tick_set[p]);
      write_reg(CfgReserveSize, size_set[p]);
      count = 0;
      while (count < 150) begin
        if ($urandom_range(0, 99) < 12) begin
          run_capture_sequence(sent);
          count += sent;
        end else begin
          w = rand_word(noise);
          send_word(w);
          if (!noise) count++;
        end
        if (p == 5 && count >= 30 && !pressure_done) begin
          pressure_req  = 1'b1;
          pressure_done = 1'b1;
        end
      end
      wait_drain();
    end

    repeat (10) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("camera_command_state_machine_tb passed");
    end else begin
      $display("camera_command_state_machine_tb failed");
    end
    $finish;
  end

endmodule
